[sv/asgr_pkg.sv]
// ----------------------------------------------------------------------------
// asgr_pkg
// shared types, character codes and the sgr code decoder for the parser
// ----------------------------------------------------------------------------
package asgr_pkg;

    localparam int MAX_PARAMS_DEF = 8;
    localparam int PARAM_W        = 14;
    localparam int COLOR_W        = 4;
    localparam int BYTE_W         = 8;

    // character codes
    localparam logic [BYTE_W-1:0] CH_ESC     = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_M       = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    localparam logic [PARAM_W-1:0] ACCUM_LIMIT   = 14'd1000;
    localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 4'd7;

    // sgr codes
    localparam logic [PARAM_W-1:0] SGR_RESET     = 14'd0;
    localparam logic [PARAM_W-1:0] SGR_BOLD_ON   = 14'd1;
    localparam logic [PARAM_W-1:0] SGR_BOLD_OFF  = 14'd22;
    localparam logic [PARAM_W-1:0] SGR_FG_DEF    = 14'd39;
    localparam logic [PARAM_W-1:0] SGR_FG_LO     = 14'd30;
    localparam logic [PARAM_W-1:0] SGR_FG_LO_END = 14'd37;
    localparam logic [PARAM_W-1:0] SGR_FG_HI     = 14'd90;
    localparam logic [PARAM_W-1:0] SGR_FG_HI_END = 14'd97;

    // ansi color order to palette order
    localparam logic [2:0] SGR_LOW_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6,
                                               3'd1, 3'd5, 3'd3, 3'd7};

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_TEXT  = 4'b0001,
        ST_ESC   = 4'b0010,
        ST_CSI   = 4'b0100,
        ST_APPLY = 4'b1000
    } t_state;

    typedef struct packed {
        logic [COLOR_W-1:0] fg;
        logic               bold;
    } t_attr;

    function automatic t_attr apply_code(input logic [PARAM_W-1:0] code,
                                         input t_attr cur);
        t_attr              res;
        logic [PARAM_W-1:0] off_lo;
        logic [PARAM_W-1:0] off_hi;
        res    = cur;
        off_lo = code - SGR_FG_LO;
        off_hi = code - SGR_FG_HI;
        if (code == SGR_RESET) begin
            res.fg   = DEFAULT_COLOR;
            res.bold = 1'b0;
        end else if (code == SGR_BOLD_ON) begin
            res.bold = 1'b1;
        end else if (code == SGR_BOLD_OFF) begin
            res.bold = 1'b0;
        end else if (code == SGR_FG_DEF) begin
            res.fg = DEFAULT_COLOR;
        end else if (code >= SGR_FG_LO && code <= SGR_FG_LO_END) begin
            res.fg = {1'b0, SGR_LOW_MAP[off_lo[2:0]]};
        end else if (code >= SGR_FG_HI && code <= SGR_FG_HI_END) begin
            res.fg = {1'b1, SGR_LOW_MAP[off_hi[2:0]]};
        end
        return res;
    endfunction

endpackage

[sv/ansi_sgr_color_parser_unit.sv]
// ----------------------------------------------------------------------------
// ansi_sgr_color_parser_unit
// byte stream parser for ESC [ ... m color sequences with color tagging
// ----------------------------------------------------------------------------
// Takes terminal output one byte per transfer on the slave stream and passes
// every ordinary byte to the master stream tagged with the effective 4-bit
// foreground color (bold lifts colors 0-7 to 8-15). ESC [ params m sequences
// are consumed without output. A terminating 'm' with parameters starts a
// walk over the stored parameters (at most MAX_PARAMS): the stored codes
// are walked one per cycle through the code decoder, and s_axis_tready
// stays low meanwhile. A finished byte sits in an output register, so the
// next byte is taken while it waits unless the register is full and the
// master side stalls.
// ----------------------------------------------------------------------------
module ansi_sgr_color_parser_unit #(
    parameter int MAX_PARAMS = asgr_pkg::MAX_PARAMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] char_out, [11:8] color_out, rest zero
);

    localparam int CNT_W = $clog2(MAX_PARAMS + 1);
    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int PW    = asgr_pkg::PARAM_W;
    localparam int CW    = asgr_pkg::COLOR_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARAMS);

    // control state
    asgr_pkg::t_state r_state, n_state;
    asgr_pkg::t_attr  r_attr, n_attr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_walk_idx, n_walk_idx;
    logic [PW-1:0]    r_accum, n_accum;
    logic             r_seen, n_seen;
    logic             r_m_valid, n_m_valid;
    // payload
    logic [7:0]       r_char, n_char;
    logic [CW-1:0]    r_color, n_color;

    // parameter store, written at the fill count, read at the walk index
    logic [PW-1:0]    r_params [MAX_PARAMS];
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [PW-1:0]    wr_data;

    logic             in_xfer;
    logic [7:0]       ch;
    logic             is_digit;
    logic [PW-1:0]    digit_val;
    logic [PW-1:0]    accum_x10;
    logic             walk_last;
    logic [PW-1:0]    walk_code;

    // input is taken only while not walking and the output slot can take a byte
    assign s_axis_tready = (r_state != asgr_pkg::ST_APPLY) && (!r_m_valid || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign ch            = s_axis_tdata;

    assign is_digit  = (ch >= asgr_pkg::CH_ZERO) && (ch <= asgr_pkg::CH_NINE);
    assign digit_val = PW'(ch - asgr_pkg::CH_ZERO);
    // accum < 1000 whenever this is used, so x10 fits the field
    assign accum_x10 = PW'({r_accum, 3'b000}) + PW'({r_accum, 1'b0});

    assign walk_code = r_params[r_walk_idx];
    assign walk_last = (CNT_W'(r_walk_idx) + CNT_W'(1)) == r_count;

    always_comb begin
        n_state    = r_state;
        n_attr     = r_attr;
        n_count    = r_count;
        n_walk_idx = r_walk_idx;
        n_accum    = r_accum;
        n_seen     = r_seen;
        n_char     = r_char;
        n_color    = r_color;
        wr_en      = 1'b0;
        wr_idx     = r_count[IDX_W-1:0];
        wr_data    = r_seen ? r_accum : '0;

        // output slot drains on a master transfer
        n_m_valid = r_m_valid && !m_axis_tready;

        unique case (r_state)
            asgr_pkg::ST_TEXT: begin
                if (in_xfer) begin
                    if (ch == asgr_pkg::CH_ESC) begin
                        n_state = asgr_pkg::ST_ESC;
                    end else begin
                        n_m_valid = 1'b1;
                        n_char    = ch;
                        // bold lifts the low eight colors
                        n_color   = {r_attr.fg[CW-1] | r_attr.bold, r_attr.fg[CW-2:0]};
                    end
                end
            end
            asgr_pkg::ST_ESC: begin
                if (in_xfer) begin
                    if (ch == asgr_pkg::CH_LBRACK) begin
                        n_state = asgr_pkg::ST_CSI;
                        n_count = '0;
                        n_accum = '0;
                        n_seen  = 1'b0;
                    end else begin
                        n_state = asgr_pkg::ST_TEXT;
                    end
                end
            end
            asgr_pkg::ST_CSI: begin
                if (in_xfer) begin
                    if (is_digit) begin
                        n_seen = 1'b1;
                        if (r_accum < asgr_pkg::ACCUM_LIMIT) begin
                            n_accum = accum_x10 + digit_val;
                        end
                    end else if (ch == asgr_pkg::CH_SEMI || ch == asgr_pkg::CH_M) begin
                        if (ch == asgr_pkg::CH_M && r_count == '0 && !r_seen) begin
                            // bare terminator: full attribute reset
                            n_attr  = asgr_pkg::apply_code(asgr_pkg::SGR_RESET, r_attr);
                            n_state = asgr_pkg::ST_TEXT;
                        end else begin
                            if (r_count < CNT_MAX) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                            n_accum = '0;
                            n_seen  = 1'b0;
                            if (ch == asgr_pkg::CH_M) begin
                                n_state    = asgr_pkg::ST_APPLY;
                                n_walk_idx = '0;
                            end
                        end
                    end else begin
                        // anything else aborts the sequence
                        n_state = asgr_pkg::ST_TEXT;
                    end
                end
            end
            asgr_pkg::ST_APPLY: begin
                // one stored code per cycle through the code decoder
                n_attr     = asgr_pkg::apply_code(walk_code, r_attr);
                n_walk_idx = r_walk_idx + IDX_W'(1);
                if (walk_last) begin
                    n_state = asgr_pkg::ST_TEXT;
                end
            end
            default: begin
                n_state = asgr_pkg::ST_TEXT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= asgr_pkg::ST_TEXT;
            r_attr     <= '{fg: asgr_pkg::DEFAULT_COLOR, bold: 1'b0};
            r_count    <= '0;
            r_walk_idx <= '0;
            r_accum    <= '0;
            r_seen     <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_attr     <= n_attr;
            r_count    <= n_count;
            r_walk_idx <= n_walk_idx;
            r_accum    <= n_accum;
            r_seen     <= n_seen;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_color <= n_color;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_params[wr_idx] <= wr_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_color, r_char};

    // the walk never reads past the filled part of the store
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == asgr_pkg::ST_APPLY |-> CNT_W'(r_walk_idx) < r_count)
        else $error("walk index beyond stored parameters");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("parameter count overflow");

    // a new result is only produced from plain text
    a_out_from_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state) == asgr_pkg::ST_TEXT)
        else $error("result produced outside text state");

    // the walk stores nothing and takes no input
    a_walk_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == asgr_pkg::ST_APPLY |-> !wr_en && !s_axis_tready)
        else $error("store written or input taken during walk");

    a_walk_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != asgr_pkg::ST_APPLY ##1 r_state == asgr_pkg::ST_APPLY
            |-> $past(r_state) == asgr_pkg::ST_CSI && r_count != '0)
        else $error("walk entered without stored parameters");

endmodule
